/* design/sgd_pkg.sv */
// Shared types and constants for the signed gamma decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sgd_pkg;

	localparam int BYTE_W   = 8;
	localparam int MAG_W    = 15;
	localparam int VAL_W    = 16;
	localparam int MAX_RES  = 4;
	localparam int CNT_W    = 3;
	localparam int IDX_W    = 2;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;

	// Bit-level parse phases of the code reader.
	localparam logic [1:0] PH_SIGN  = 2'd0;
	localparam logic [1:0] PH_ZEROS = 2'd1;
	localparam logic [1:0] PH_MAG   = 2'd2;

	localparam logic [MAG_W-1:0] MAG_MAX  = 15'h7FFF;
	localparam logic [MAG_W-1:0] MAG_HALF = 15'h3FFF;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    err;
	} result_t;

	// All results that one byte produced, oldest in slot 0.
	typedef struct packed {
		logic [CNT_W-1:0]          count;
		result_t [MAX_RES-1:0]     res;
	} batch_t;

	function automatic result_t make_result(input logic [MAG_W-1:0] mag,
	                                        input logic neg, input logic err);
		result_t r;
		logic [VAL_W-1:0] ext;
		ext = {1'b0, mag};
		r.value = neg ? -ext : ext;
		r.err = err;
		return r;
	endfunction

endpackage

/* design/sgd_front.sv */
// Front end: accepts coded bytes, walks their eight bits and builds one batch
// of decoded results per byte. Depends on sgd_pkg.
module sgd_front #(
	parameter int MAX_CODE_BITS = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [sgd_pkg::BYTE_W-1:0]    code_byte,
	input  logic                          q_full,
	output logic                          push,
	output sgd_pkg::batch_t               batch
);

	localparam int ZW = $clog2(MAX_CODE_BITS + 1);
	localparam logic [ZW-1:0] ZMAX = ZW'(MAX_CODE_BITS);

	logic [1:0]                phase_q;
	logic                      neg_q;
	logic [ZW-1:0]             zrun_q;
	logic [ZW-1:0]             left_q;
	logic [sgd_pkg::MAG_W-1:0] mag_q;

	logic [1:0]                ph;
	logic                      neg;
	logic [ZW-1:0]             zr;
	logic [ZW-1:0]             bl;
	logic [sgd_pkg::MAG_W-1:0] mag;
	logic [sgd_pkg::CNT_W-1:0] n;
	logic                      b;
	logic                      accept;

	assign byte_stall = q_full;
	assign accept = byte_valid && !q_full;

	// Eight dependent bit steps over narrow state; a result slot is filled
	// each time a code completes or a zero run overflows.
	always_comb begin
		ph = phase_q;
		neg = neg_q;
		zr = zrun_q;
		bl = left_q;
		mag = mag_q;
		n = '0;
		b = 1'b0;
		batch = '0;
		for (int i = 0; i < sgd_pkg::BYTE_W; i++) begin
			b = code_byte[i];
			case (ph)
				sgd_pkg::PH_ZEROS: begin
					if (!b) begin
						if (zr >= ZMAX) begin
							if (n < 3'(sgd_pkg::MAX_RES)) begin
								batch.res[n[sgd_pkg::IDX_W-1:0]] =
									sgd_pkg::make_result('0, 1'b0, 1'b1);
								n = n + 3'd1;
							end
							ph = sgd_pkg::PH_SIGN;
							zr = '0;
							bl = '0;
							mag = '0;
						end else begin
							zr = zr + ZW'(1);
						end
					end else if (zr == '0) begin
						if (n < 3'(sgd_pkg::MAX_RES)) begin
							batch.res[n[sgd_pkg::IDX_W-1:0]] =
								sgd_pkg::make_result('0, neg, 1'b0);
							n = n + 3'd1;
						end
						ph = sgd_pkg::PH_SIGN;
						zr = '0;
						bl = '0;
						mag = '0;
					end else begin
						mag = sgd_pkg::MAG_W'(1);
						bl = zr - ZW'(1);
						if (bl == '0) begin
							if (n < 3'(sgd_pkg::MAX_RES)) begin
								batch.res[n[sgd_pkg::IDX_W-1:0]] =
									sgd_pkg::make_result(mag, neg, 1'b0);
								n = n + 3'd1;
							end
							ph = sgd_pkg::PH_SIGN;
							zr = '0;
							bl = '0;
							mag = '0;
						end else begin
							ph = sgd_pkg::PH_MAG;
						end
					end
				end
				sgd_pkg::PH_MAG: begin
					// Magnitudes wider than the field saturate.
					if (mag > sgd_pkg::MAG_HALF) begin
						mag = sgd_pkg::MAG_MAX;
					end else begin
						mag = {mag[sgd_pkg::MAG_W-2:0], b};
					end
					bl = bl - ZW'(1);
					if (bl == '0) begin
						if (n < 3'(sgd_pkg::MAX_RES)) begin
							batch.res[n[sgd_pkg::IDX_W-1:0]] =
								sgd_pkg::make_result(mag, neg, 1'b0);
							n = n + 3'd1;
						end
						ph = sgd_pkg::PH_SIGN;
						zr = '0;
						bl = '0;
						mag = '0;
					end
				end
				default: begin
					neg = !b;
					zr = '0;
					bl = '0;
					mag = '0;
					ph = sgd_pkg::PH_ZEROS;
				end
			endcase
		end
		batch.count = n;
	end

	assign push = accept && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sgd_pkg::PH_SIGN;
			neg_q <= 1'b0;
			zrun_q <= '0;
			left_q <= '0;
			mag_q <= '0;
		end else if (accept) begin
			phase_q <= ph;
			neg_q <= neg;
			zrun_q <= zr;
			left_q <= bl;
			mag_q <= mag;
		end
	end

endmodule

/* design/sgd_queue.sv */
// Short FIFO of result batches between the front and back ends.
// Depends on sgd_pkg.
module sgd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sgd_pkg::batch_t wr_batch,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sgd_pkg::batch_t head
);

	sgd_pkg::batch_t                 mem [sgd_pkg::QDEPTH];
	logic [sgd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [sgd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [sgd_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full = (cnt_q == sgd_pkg::QCNT_W'(sgd_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/sgd_back.sv */
// Back end: drains the head batch one result per cycle while not stalled into
// the output register and marks the last result of each byte. Depends on sgd_pkg.
module sgd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  sgd_pkg::batch_t                   head,
	output logic                              pop,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [sgd_pkg::VAL_W-1:0]  value,
	output logic                              overflow_error,
	output logic                              last_of_byte
);

	logic [sgd_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic                      load;
	logic                      last;
	sgd_pkg::result_t          cur;

	assign cur = head.res[idx_q];
	assign last = ({1'b0, idx_q} == (head.count - 3'd1));
	// The output register reloads whenever a batch is queued and the register is empty or being taken.
	assign load = head_valid && (!out_valid_q || !result_stall);
	assign pop = load && last;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			value <= cur.value;
			overflow_error <= cur.err;
			last_of_byte <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= last ? '0 : idx_q + 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/signed_gamma_decoder.sv */
// Signed Elias gamma decoder: one coded byte in, zero to four signed values out.
// A byte's results pass through the queue and then the output register before they appear.
// A byte is taken every cycle while the four-batch queue has room; results leave
// at one per cycle while result_stall is low.
// Reset: arst_n clears the parse state, the queue pointers and count, and the output valid flag.
// Depends on sgd_pkg, sgd_front, sgd_queue and sgd_back.
module signed_gamma_decoder #(
	parameter int MAX_CODE_BITS = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [sgd_pkg::BYTE_W-1:0]        code_byte,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [sgd_pkg::VAL_W-1:0]  value,
	output logic                              overflow_error,
	output logic                              last_of_byte
);

	logic            push;
	logic            q_full;
	logic            pop;
	logic            head_valid;
	sgd_pkg::batch_t wr_batch;
	sgd_pkg::batch_t head;

	sgd_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.code_byte(code_byte),
		.q_full(q_full),
		.push(push),
		.batch(wr_batch)
	);

	sgd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_batch(wr_batch),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	sgd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.value(value),
		.overflow_error(overflow_error),
		.last_of_byte(last_of_byte)
	);

endmodule
